// ===== sv/hsv2rgb_pkg.sv =====
package hsv2rgb_pkg;

  // fixed point format of saturation and value
  localparam int FRAC_BITS = 8;
  localparam int ONE       = 1 << FRAC_BITS;

  // field widths
  localparam int HUE_W  = 16;
  localparam int IN_W   = 16;
  localparam int CHAN_W = 8;

  // angle and scale constants
  localparam int CIRCLE_DEG = 360;
  localparam int SECTOR_DEG = 60;
  localparam int FULL_SCALE = 255;

  // clamped unit value 0..ONE
  localparam int UNIT_W = FRAC_BITS + 1;
  // 60*ONE - s*k and its product with v
  localparam int W_W     = FRAC_BITS + 6;
  localparam int PROD_W  = 2 * FRAC_BITS + 6;
  localparam int SCALE_W = PROD_W + 8;
  // 255*v*w / ONE^2 is at most 255*60
  localparam int Y_W = 14;

  // hue biased into a nonnegative range by a multiple of 360
  localparam int HUE_BIAS = 92 * CIRCLE_DEG;
  localparam int HUE_X_W  = 17;

  // divide by 60 through a reciprocal, exact for x below 2^17
  localparam int DIV60_RECIP = 139811;
  localparam int DIV60_SHIFT = 23;
  localparam int DIV60_M_W   = 35;
  localparam int Q_W         = 11;

  // divide the 60-degree count by 6, exact for q below 2^11
  localparam int DIV6_RECIP = 1366;
  localparam int DIV6_SHIFT = 13;
  localparam int DIV6_M_W   = 22;
  localparam int QQ_W       = 8;

  localparam int REM_W  = 6;
  localparam int SECT_W = 3;

  // final divide by 60 of the scaled channel, exact for y below 2^14
  localparam int Y_RECIP = 17477;
  localparam int Y_SHIFT = 20;
  localparam int Y_M_W   = 29;

  typedef enum logic [SECT_W-1:0] {
    SECT_R_TO_Y = 3'd0,
    SECT_Y_TO_G = 3'd1,
    SECT_G_TO_C = 3'd2,
    SECT_C_TO_B = 3'd3,
    SECT_B_TO_M = 3'd4,
    SECT_M_TO_R = 3'd5
  } sector_t;

  // stage advance strobes of one channel lane
  typedef struct packed {
    logic en_mul;
    logic en_prod;
    logic en_scale;
    logic en_div;
  } chan_ctl_t;

  // clamp a signed fixed point value into 0..ONE
  function automatic logic [UNIT_W-1:0] clamp_unit(input logic signed [IN_W-1:0] x);
    logic [IN_W:0] mag;
    mag = {1'b0, x};
    if (x[IN_W-1]) begin
      return '0;
    end else if (mag > (IN_W+1)'(ONE)) begin
      return UNIT_W'(ONE);
    end else begin
      return UNIT_W'(x);
    end
  endfunction

endpackage

// ===== sv/hsv_if.sv =====
interface hsv_if import hsv2rgb_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [HUE_W-1:0] hue_deg;
  logic signed [IN_W-1:0]  saturation;
  logic signed [IN_W-1:0]  brightness;

  modport source (output valid, output hue_deg, output saturation, output brightness,
                  input ready);
  modport sink (input valid, input hue_deg, input saturation, input brightness,
                output ready);
endinterface

// ===== sv/rgb_if.sv =====
interface rgb_if import hsv2rgb_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ===== sv/hsv2rgb_chan.sv =====
module hsv2rgb_chan import hsv2rgb_pkg::*; (
  input  logic              clk,
  input  chan_ctl_t         ctl,
  input  logic [UNIT_W-1:0] sat,
  input  logic [UNIT_W-1:0] val,
  input  logic [REM_W-1:0]  k,
  output logic [CHAN_W-1:0] chan
);

  localparam logic [W_W-1:0] W_FULL = W_W'(SECTOR_DEG * ONE);

  logic [W_W-1:0]     w;
  logic [UNIT_W-1:0]  val_a;
  logic [PROD_W-1:0]  prod;
  logic [Y_W-1:0]     y;
  logic [SCALE_W-1:0] scaled;

  // 60*ONE - s*k
  always_ff @(posedge clk) begin
    if (ctl.en_mul) begin
      w     <= W_FULL - W_W'(sat) * W_W'(k);
      val_a <= val;
    end
  end

  // v * (60*ONE - s*k)
  always_ff @(posedge clk) begin
    if (ctl.en_prod) begin
      prod <= PROD_W'(val_a) * PROD_W'(w);
    end
  end

  // times 255, drop the two fraction scales
  assign scaled = (SCALE_W'(prod) << 8) - SCALE_W'(prod);

  always_ff @(posedge clk) begin
    if (ctl.en_scale) begin
      y <= Y_W'(scaled >> (2 * FRAC_BITS));
    end
  end

  // truncating divide by 60
  always_ff @(posedge clk) begin
    if (ctl.en_div) begin
      chan <= CHAN_W'((Y_M_W'(y) * Y_M_W'(Y_RECIP)) >> Y_SHIFT);
    end
  end

endmodule

// ===== sv/hsv_to_rgb_converter_core.sv =====
// hsv to rgb pixel converter, seven register stages
// a request passes stage 1, stage 2, the four lanes and the output register to rgb
// throughput: one pixel per cycle while rgb is ready; each stage holds one item
// and moves on once its successor has room, so empty stages fill up during a stall
// reset: rst clears all stage valid flags, data registers are not reset
module hsv_to_rgb_converter_core import hsv2rgb_pkg::*; (
  input  logic clk,
  input  logic rst,
  hsv_if.sink  hsv,
  rgb_if.source rgb
);

  localparam logic [REM_W-1:0] K_FULL = REM_W'(SECTOR_DEG);

  // stage valid flags
  logic s1_valid, s2_valid, a_valid, b_valid, c_valid, d_valid, out_valid;
  // stage advance strobes
  logic en1, en2, en_a, en_b, en_c, en_d, en_out;

  // stage 1 data
  logic [UNIT_W-1:0]  s1_sat, s1_val;
  logic [HUE_X_W-1:0] s1_x;
  logic [Q_W-1:0]     s1_q;
  // stage 2 data
  logic [UNIT_W-1:0]  s2_sat, s2_val;
  logic [REM_W-1:0]   s2_rem;
  logic [Q_W-1:0]     s2_q;
  logic [QQ_W-1:0]    s2_qq;
  // sector through the lane stages
  sector_t sect_a, sect_b, sect_c, sect_d;

  logic signed [HUE_X_W:0] hue_biased;
  logic [HUE_X_W-1:0]      hue_x;
  logic [REM_W-1:0]        k_t;
  logic [Q_W-1:0]          sect_raw;
  chan_ctl_t               lane_ctl;
  logic [CHAN_W-1:0]       cv, cp, cq, ct;
  logic [CHAN_W-1:0]       red, green, blue;

  // each stage takes new data when it is empty or its successor moves
  always_comb begin
    en_out = !out_valid || rgb.ready;
    en_d   = !d_valid   || en_out;
    en_c   = !c_valid   || en_d;
    en_b   = !b_valid   || en_c;
    en_a   = !a_valid   || en_b;
    en2    = !s2_valid  || en_a;
    en1    = !s1_valid  || en2;
  end

  assign hsv.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1)    s1_valid  <= hsv.valid;
      if (en2)    s2_valid  <= s1_valid;
      if (en_a)   a_valid   <= s2_valid;
      if (en_b)   b_valid   <= a_valid;
      if (en_c)   c_valid   <= b_valid;
      if (en_d)   d_valid   <= c_valid;
      if (en_out) out_valid <= d_valid;
    end
  end

  // stage 1: clamp, bias hue nonnegative, hue / 60
  assign hue_biased = (HUE_X_W+1)'(hsv.hue_deg) + (HUE_X_W+1)'(HUE_BIAS);
  assign hue_x      = hue_biased[HUE_X_W-1:0];

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_sat <= clamp_unit(hsv.saturation);
      s1_val <= clamp_unit(hsv.brightness);
      s1_x   <= hue_x;
      s1_q   <= Q_W'((DIV60_M_W'(hue_x) * DIV60_M_W'(DIV60_RECIP)) >> DIV60_SHIFT);
    end
  end

  // stage 2: remainder within the sector, count / 6
  always_ff @(posedge clk) begin
    if (en2) begin
      s2_sat <= s1_sat;
      s2_val <= s1_val;
      s2_q   <= s1_q;
      s2_rem <= REM_W'(s1_x - HUE_X_W'(s1_q) * HUE_X_W'(SECTOR_DEG));
      s2_qq  <= QQ_W'((DIV6_M_W'(s1_q) * DIV6_M_W'(DIV6_RECIP)) >> DIV6_SHIFT);
    end
  end

  // sector is the 60-degree count modulo 6
  assign sect_raw = s2_q - Q_W'(s2_qq) * Q_W'(6);
  assign k_t      = K_FULL - s2_rem;

  always_ff @(posedge clk) begin
    if (en_a) sect_a <= sector_t'(sect_raw[SECT_W-1:0]);
    if (en_b) sect_b <= sect_a;
    if (en_c) sect_c <= sect_b;
    if (en_d) sect_d <= sect_c;
  end

  // four channel lanes: v, p, q, t
  always_comb begin
    lane_ctl.en_mul   = en_a;
    lane_ctl.en_prod  = en_b;
    lane_ctl.en_scale = en_c;
    lane_ctl.en_div   = en_d;
  end

  hsv2rgb_chan u_lane_v (
    .clk(clk), .ctl(lane_ctl), .sat(s2_sat), .val(s2_val), .k('0), .chan(cv)
  );
  hsv2rgb_chan u_lane_p (
    .clk(clk), .ctl(lane_ctl), .sat(s2_sat), .val(s2_val), .k(K_FULL), .chan(cp)
  );
  hsv2rgb_chan u_lane_q (
    .clk(clk), .ctl(lane_ctl), .sat(s2_sat), .val(s2_val), .k(s2_rem), .chan(cq)
  );
  hsv2rgb_chan u_lane_t (
    .clk(clk), .ctl(lane_ctl), .sat(s2_sat), .val(s2_val), .k(k_t), .chan(ct)
  );

  // channel ordering per sector
  always_ff @(posedge clk) begin
    if (en_out) begin
      unique case (sect_d)
        SECT_Y_TO_G: begin red <= cq; green <= cv; blue <= cp; end
        SECT_G_TO_C: begin red <= cp; green <= cv; blue <= ct; end
        SECT_C_TO_B: begin red <= cp; green <= cq; blue <= cv; end
        SECT_B_TO_M: begin red <= ct; green <= cp; blue <= cv; end
        SECT_M_TO_R: begin red <= cv; green <= cp; blue <= cq; end
        default:     begin red <= cv; green <= ct; blue <= cp; end
      endcase
    end
  end

  assign rgb.valid = out_valid;
  assign rgb.red   = red;
  assign rgb.green = green;
  assign rgb.blue  = blue;

endmodule

// ===== sv/hsv2rgb_checker.sv =====
module hsv2rgb_checker import hsv2rgb_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAN_W-1:0] red,
  input logic [CHAN_W-1:0] green,
  input logic [CHAN_W-1:0] blue
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({red, green, blue}))
    else $error("stalled rgb result changed");

  // with room at the output the whole pipe advances
  assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("hsv not ready although output can move");

  // nothing comes out right after reset
  assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("rgb valid right after reset");

  // fixed latency while the output side keeps taking results
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready
      ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("rgb result missing after pipeline latency");

endmodule

bind hsv_to_rgb_converter_core hsv2rgb_checker u_hsv2rgb_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(hsv.valid),
  .in_ready(hsv.ready),
  .out_valid(rgb.valid),
  .out_ready(rgb.ready),
  .red(rgb.red),
  .green(rgb.green),
  .blue(rgb.blue)
);

// ===== tb/sv/rgb_pixel_checker.sv =====
// watches both channels, predicts each pixel and compares it with the rgb output
module rgb_pixel_checker import hsv2rgb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  hsv_if              hsv,
  rgb_if              rgb,
  output int unsigned mismatches,
  output int unsigned outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_pix_t;

  typedef struct {
    logic signed [HUE_W-1:0] hue_deg;
    logic signed [IN_W-1:0]  saturation;
    logic signed [IN_W-1:0]  brightness;
    rgb_pix_t                pix;
  } pixel_expect_t;

  pixel_expect_t pixel_q[$];

  // saturate a signed fixed point input into 0..ONE
  function automatic longint limit_unit(input logic signed [IN_W-1:0] x);
    if (x < 0) begin
      return 0;
    end else if (int'(x) > ONE) begin
      return ONE;
    end
    return longint'(x);
  endfunction

  // floor(255 * v * (60*ONE - s*k) / (60*ONE*ONE))
  function automatic logic [CHAN_W-1:0] scaled_channel(input longint v, input longint s,
                                                        input longint k);
    longint num;
    longint den;
    num = longint'(SECTOR_DEG) * ONE - s * k;
    den = longint'(SECTOR_DEG) * ONE * ONE;
    return CHAN_W'((longint'(FULL_SCALE) * v * num) / den);
  endfunction

  // expected color for one hsv request
  function automatic rgb_pix_t hsv_to_rgb_expected(input logic signed [HUE_W-1:0] h,
                                                   input logic signed [IN_W-1:0]  s_in,
                                                   input logic signed [IN_W-1:0]  v_in);
    int                hue;
    longint            s;
    longint            v;
    longint            rem;
    logic [CHAN_W-1:0] cv;
    logic [CHAN_W-1:0] cp;
    logic [CHAN_W-1:0] cq;
    logic [CHAN_W-1:0] ct;
    rgb_pix_t          pix;
    hue = int'(h) % CIRCLE_DEG;
    if (hue < 0) begin
      hue += CIRCLE_DEG;
    end
    s   = limit_unit(s_in);
    v   = limit_unit(v_in);
    rem = hue % SECTOR_DEG;
    cv  = scaled_channel(v, s, 0);
    cp  = scaled_channel(v, s, SECTOR_DEG);
    cq  = scaled_channel(v, s, rem);
    ct  = scaled_channel(v, s, SECTOR_DEG - rem);
    case (sector_t'(hue / SECTOR_DEG))
      SECT_Y_TO_G: pix = '{red: cq, green: cv, blue: cp};
      SECT_G_TO_C: pix = '{red: cp, green: cv, blue: ct};
      SECT_C_TO_B: pix = '{red: cp, green: cq, blue: cv};
      SECT_B_TO_M: pix = '{red: ct, green: cp, blue: cv};
      SECT_M_TO_R: pix = '{red: cv, green: cp, blue: cq};
      default:     pix = '{red: cv, green: ct, blue: cp};
    endcase
    return pix;
  endfunction

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // record requests and check results at each rising edge
  always @(posedge clk) begin
    pixel_expect_t exp_px;
    rgb_pix_t      got;
    if (!rst) begin
      if (hsv.valid && hsv.ready) begin
        exp_px.hue_deg    = hsv.hue_deg;
        exp_px.saturation = hsv.saturation;
        exp_px.brightness = hsv.brightness;
        exp_px.pix        = hsv_to_rgb_expected(hsv.hue_deg, hsv.saturation,
                                                hsv.brightness);
        pixel_q.push_back(exp_px);
      end
      if (rgb.valid && rgb.ready) begin
        got = '{red: rgb.red, green: rgb.green, blue: rgb.blue};
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected rgb result, expected none, got %0d/%0d/%0d",
                   $realtime, got.red, got.green, got.blue);
          mismatches <= mismatches + 1;
        end else begin
          exp_px = pixel_q.pop_front();
          // compare each channel
          if (got.red !== exp_px.pix.red || got.green !== exp_px.pix.green ||
              got.blue !== exp_px.pix.blue) begin
            $display("%0t: rgb mismatch for h=%0d s=%0d v=%0d: %s %0d/%0d/%0d, %s %0d/%0d/%0d",
                     $realtime, exp_px.hue_deg, exp_px.saturation, exp_px.brightness,
                     "expected", exp_px.pix.red, exp_px.pix.green, exp_px.pix.blue,
                     "got", got.red, got.green, got.blue);
            mismatches <= mismatches + 1;
          end
        end
      end
      outstanding <= pixel_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_hsv_to_rgb_converter_core.sv =====
module tb_hsv_to_rgb_converter_core import hsv2rgb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PIXELS = 1225;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_AT_PIXEL = 300;
  localparam int HOLD_CYCLES   = 120;
  localparam int DRAIN_CYCLES  = 12;

  typedef struct packed {
    logic signed [HUE_W-1:0] hue;
    logic signed [IN_W-1:0]  sat;
    logic signed [IN_W-1:0]  bri;
  } hsv_pix_t;

  logic        clk;
  logic        rst;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned cycle_count;
  int unsigned sent_count;
  bit          hold_rgb;
  bit          tx_calm;
  bit          rx_calm;

  hsv_if hsv ();
  rgb_if rgb ();

  hsv_to_rgb_converter_core DUT (
    .clk (clk),
    .rst (rst),
    .hsv (hsv),
    .rgb (rgb)
  );

  rgb_pixel_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .hsv         (hsv),
    .rgb         (rgb),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // sector edges, hue wrap, clamping on both ends and zero saturation
  hsv_pix_t corner_px [25] = '{
    '{16'sd0,      16'sd256,    16'sd256},
    '{16'sd60,     16'sd256,    16'sd256},
    '{16'sd120,    16'sd256,    16'sd256},
    '{16'sd180,    16'sd256,    16'sd256},
    '{16'sd240,    16'sd256,    16'sd256},
    '{16'sd300,    16'sd256,    16'sd256},
    '{16'sd359,    16'sd256,    16'sd256},
    '{16'sd360,    16'sd256,    16'sd256},
    '{-16'sd1,     16'sd256,    16'sd256},
    '{-16'sd360,   16'sd200,    16'sd256},
    '{16'sh8000,   16'sd128,    16'sd200},
    '{16'sh7fff,   16'sd128,    16'sd200},
    '{16'sd30,     16'sd0,      16'sd256},
    '{16'sd200,    16'sd0,      16'sd100},
    '{16'sd90,     16'sh8000,   16'sd256},
    '{16'sd90,     -16'sd1,     16'sh7fff},
    '{16'sd150,    16'sd257,    16'sd256},
    '{16'sd210,    16'sh7fff,   16'sd255},
    '{16'sd270,    16'sd255,    16'sh8000},
    '{16'sd330,    16'sd1,      -16'sd1},
    '{16'sd45,     16'sd256,    16'sd257},
    '{16'sd59,     16'sd256,    16'sd1},
    '{16'sd119,    16'sd128,    16'sd0},
    '{16'sd299,    16'sd255,    16'sd255},
    '{16'sh7fff,   16'sh7fff,   16'sh7fff}
  };

  // wait length for one request, none during a calm stretch
  function automatic int unsigned idle_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  // saturation or value: mostly in range, some near the clamp edges, some anything
  function automatic logic signed [IN_W-1:0] random_unit();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      return IN_W'($urandom);
    end else if (pick < 4) begin
      return IN_W'($urandom_range(0, 1) ? int'($urandom_range(0, 4)) - 2
                                        : ONE - 2 + int'($urandom_range(0, 4)));
    end
    return IN_W'($urandom_range(0, ONE));
  endfunction

  // offer one request and hold it until accepted
  task automatic send_pixel(input hsv_pix_t px);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) begin
      tx_calm = !tx_calm;
    end
    gap = hold_rgb ? 0 : idle_gap(tx_calm);
    @(negedge clk);
    if (gap > 0) begin
      hsv.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    hsv.valid      <= 1'b1;
    hsv.hue_deg    <= px.hue;
    hsv.saturation <= px.sat;
    hsv.brightness <= px.bri;
    @(posedge clk);
    while (!hsv.ready) @(posedge clk);
    sent_count++;
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle counter for the run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // long receiver hold-off so the pipeline fills and stalls its input
  initial begin
    hold_rgb = 1'b0;
    wait (sent_count >= HOLD_AT_PIXEL);
    @(posedge clk);
    hold_rgb = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rgb = 1'b0;
  end

  // result side: random stalls per result
  initial begin
    int unsigned gap;
    rgb.ready = 1'b0;
    rx_calm   = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) begin
        rx_calm = !rx_calm;
      end
      gap = idle_gap(rx_calm);
      while (gap > 0 || hold_rgb) begin
        rgb.ready <= 1'b0;
        if (gap > 0) begin
          gap--;
        end
        @(negedge clk);
      end
      rgb.ready <= 1'b1;
      @(posedge clk);
      while (!rgb.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // request side and verdict
  initial begin
    hsv_pix_t px;
    cycle_count    = 0;
    sent_count     = 0;
    tx_calm        = 1'b0;
    rst            = 1'b1;
    hsv.valid      = 1'b0;
    hsv.hue_deg    = '0;
    hsv.saturation = '0;
    hsv.brightness = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (corner_px[i]) begin
      send_pixel(corner_px[i]);
    end

    repeat (RANDOM_PIXELS) begin
      if ($urandom_range(0, 3) == 0) begin
        px.hue = HUE_W'($urandom);
      end else begin
        px.hue = HUE_W'(int'($urandom_range(0, 1079)) - 720);
      end
      px.sat = random_unit();
      px.bri = random_unit();
      send_pixel(px);
    end
    @(negedge clk);
    hsv.valid <= 1'b0;

    // drain the pipeline, then give stray results time to show
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/hsv2rgb_pkg.sv
sv/hsv_if.sv
sv/rgb_if.sv
sv/hsv2rgb_chan.sv
sv/hsv_to_rgb_converter_core.sv
sv/hsv2rgb_checker.sv
tb/sv/rgb_pixel_checker.sv
tb/sv/tb_hsv_to_rgb_converter_core.sv
